[src/sva_pkg.sv]
`default_nettype none

package sva_pkg;

  localparam int VoicesDef = 16;

  localparam int ActW   = 3;
  localparam int NoteW  = 7;
  localparam int VoiceW = 4;
  localparam int PeakW  = 31;
  localparam int LimW   = 4;
  localparam int MaskW  = 16;
  localparam int CfgIdxW = 1;

  localparam logic [PeakW-1:0] QuietThrRst = PeakW'(2048);
  localparam logic [LimW-1:0]  QuietLimRst = LimW'(4);
  localparam logic [LimW-1:0]  QuietMax    = LimW'(15);

  // host action codes
  localparam logic [ActW-1:0] ACT_NOTE_ON  = 3'd0;
  localparam logic [ActW-1:0] ACT_NOTE_OFF = 3'd1;
  localparam logic [ActW-1:0] ACT_ALL_OFF  = 3'd2;
  localparam logic [ActW-1:0] ACT_PEAK     = 3'd3;
  localparam logic [ActW-1:0] ACT_RESET    = 3'd4;

  // config register indexes
  localparam logic [CfgIdxW-1:0] CFG_QUIET_THRESHOLD = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_QUIET_LIMIT     = 1'b1;

  // operation carried by the token through the cell chain
  typedef enum logic [2:0] {
    OP_NONE,
    OP_ON_FREE,
    OP_ON_STEAL,
    OP_OFF,
    OP_ALL_OFF,
    OP_PEAK,
    OP_RESET
  } sva_op_e;

  typedef struct packed {
    logic                 vld;
    sva_op_e              op;
    logic [NoteW-1:0]     note;
    logic                 quiet;
    logic                 taken;
    logic [VoiceW-1:0]    assigned;
    logic [MaskW-1:0]     mask;
    logic                 freed;
  } sva_token_t;

endpackage

`default_nettype wire

[src/sva_cell.sv]
`default_nettype none

module sva_cell #(
  parameter int VOICES = sva_pkg::VoicesDef,
  parameter int IDX    = 0
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic [sva_pkg::LimW-1:0]  limit_i,
  input  wire sva_pkg::sva_token_t       tok_i,
  input  wire logic [$clog2(VOICES)-1:0] tgt_i,
  output sva_pkg::sva_token_t            tok_o,
  output logic [$clog2(VOICES)-1:0]      tgt_o
);

  localparam int IdxW = $clog2(VOICES);
  localparam logic [sva_pkg::VoiceW-1:0] MyIdx = sva_pkg::VoiceW'(IDX);
  // voices past the mask width get no bit
  localparam logic [sva_pkg::MaskW-1:0]  MyBit = sva_pkg::MaskW'(1) << IDX;

  logic                        active_q, active_d;
  logic                        gate_q, gate_d;
  logic [sva_pkg::NoteW-1:0]   note_q, note_d;
  logic [sva_pkg::LimW-1:0]    qc_q, qc_d;
  sva_pkg::sva_token_t         tok_q, tok_d;
  logic [IdxW-1:0]             tgt_q;
  logic                        hit;
  logic [sva_pkg::LimW-1:0]    qc_next;

  assign hit = (tgt_i == IdxW'(IDX));

  always_comb begin
    if (!tok_i.quiet) begin
      qc_next = '0;
    end else if (qc_q == sva_pkg::QuietMax) begin
      qc_next = sva_pkg::QuietMax;
    end else begin
      qc_next = qc_q + sva_pkg::LimW'(1);
    end
  end

  always_comb begin
    active_d = active_q;
    gate_d   = gate_q;
    note_d   = note_q;
    qc_d     = qc_q;
    tok_d    = tok_i;
    if (tok_i.vld) begin
      case (tok_i.op)
        sva_pkg::OP_ON_FREE, sva_pkg::OP_ON_STEAL: begin
          if ((tok_i.op == sva_pkg::OP_ON_FREE && !tok_i.taken && !active_q) ||
              (tok_i.op == sva_pkg::OP_ON_STEAL && hit)) begin
            active_d       = 1'b1;
            gate_d         = 1'b1;
            note_d         = tok_i.note;
            qc_d           = '0;
            tok_d.taken    = 1'b1;
            tok_d.assigned = MyIdx;
          end
        end
        sva_pkg::OP_OFF: begin
          if (active_q && gate_q && note_q == tok_i.note) begin
            gate_d     = 1'b0;
            tok_d.mask = tok_i.mask | MyBit;
          end
        end
        sva_pkg::OP_ALL_OFF, sva_pkg::OP_RESET: begin
          if (active_q) begin
            if (gate_q) tok_d.mask = tok_i.mask | MyBit;
            gate_d = 1'b0;
          end
          if (tok_i.op == sva_pkg::OP_RESET) active_d = 1'b0;
        end
        sva_pkg::OP_PEAK: begin
          if (hit && active_q && !gate_q) begin
            qc_d = qc_next;
            if (qc_next >= limit_i) begin
              active_d    = 1'b0;
              tok_d.freed = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      gate_q   <= 1'b0;
      note_q   <= '0;
      qc_q     <= '0;
      tok_q    <= '0;
      tgt_q    <= '0;
    end else begin
      active_q <= active_d;
      gate_q   <= gate_d;
      note_q   <= note_d;
      qc_q     <= qc_d;
      tok_q    <= tok_d;
      tgt_q    <= tgt_i;
    end
  end

  assign tok_o = tok_q;
  assign tgt_o = tgt_q;

endmodule

`default_nettype wire

[src/sva_ctrl.sv]
`default_nettype none

module sva_ctrl #(
  parameter int VOICES = sva_pkg::VoicesDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  output logic                              busy_o,
  input  wire logic [sva_pkg::ActW-1:0]     action_i,
  input  wire logic [sva_pkg::NoteW-1:0]    note_i,
  input  wire logic [sva_pkg::VoiceW-1:0]   voice_i,
  input  wire logic [sva_pkg::PeakW-1:0]    peak_i,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [sva_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [sva_pkg::PeakW-1:0]    cfg_data_i,
  output logic [sva_pkg::LimW-1:0]          limit_o,
  input  wire sva_pkg::sva_token_t          tail_i,
  output sva_pkg::sva_token_t               head_o,
  output logic [$clog2(VOICES)-1:0]         tgt_o
);

  localparam int IdxW = $clog2(VOICES);
  localparam int CntW = $clog2(VOICES + 1);
  localparam int ExtW = IdxW + sva_pkg::VoiceW;

  logic                        busy_q;
  logic [sva_pkg::PeakW-1:0]   thr_q;
  logic [sva_pkg::LimW-1:0]    lim_q;
  logic [IdxW-1:0]             ptr_q, ptr_d;
  logic [CntW-1:0]             cnt_q, cnt_d;
  sva_pkg::sva_token_t         tok_q, tok_d;
  logic [IdxW-1:0]             tgt_q, tgt_d;
  logic                        accept;
  logic                        full;
  logic [ExtW-1:0]             voice_ext;

  assign accept      = start_i && !busy_q;
  assign full        = (cnt_q == CntW'(VOICES));
  assign voice_ext   = ExtW'(voice_i);
  assign cfg_ready_o = 1'b1;

  always_comb begin
    ptr_d          = ptr_q;
    tgt_d          = voice_ext[IdxW-1:0];
    tok_d          = '0;
    tok_d.vld      = 1'b1;
    tok_d.note     = note_i;
    tok_d.quiet    = (peak_i < thr_q);
    tok_d.op       = sva_pkg::OP_NONE;
    case (action_i)
      sva_pkg::ACT_NOTE_ON: begin
        if (full) begin
          tok_d.op = sva_pkg::OP_ON_STEAL;
          tgt_d    = ptr_q;
          ptr_d    = (ptr_q == IdxW'(VOICES - 1)) ? '0 : ptr_q + IdxW'(1);
        end else begin
          tok_d.op = sva_pkg::OP_ON_FREE;
        end
      end
      sva_pkg::ACT_NOTE_OFF: tok_d.op = sva_pkg::OP_OFF;
      sva_pkg::ACT_ALL_OFF:  tok_d.op = sva_pkg::OP_ALL_OFF;
      sva_pkg::ACT_PEAK: begin
        if (voice_ext < ExtW'(VOICES)) tok_d.op = sva_pkg::OP_PEAK;
      end
      sva_pkg::ACT_RESET:    tok_d.op = sva_pkg::OP_RESET;
      default: ;
    endcase
  end

  // active voice count follows the token as it leaves the chain
  always_comb begin
    cnt_d = cnt_q;
    if (tail_i.vld) begin
      case (tail_i.op)
        sva_pkg::OP_ON_FREE: cnt_d = cnt_q + CntW'(1);
        sva_pkg::OP_PEAK:    if (tail_i.freed) cnt_d = cnt_q - CntW'(1);
        sva_pkg::OP_RESET:   cnt_d = '0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      thr_q  <= sva_pkg::QuietThrRst;
      lim_q  <= sva_pkg::QuietLimRst;
      ptr_q  <= '0;
      cnt_q  <= '0;
      tok_q  <= '0;
      tgt_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (accept) begin
        busy_q <= 1'b1;
        ptr_q  <= ptr_d;
        tok_q  <= tok_d;
        tgt_q  <= tgt_d;
      end else begin
        tok_q.vld <= 1'b0;
        if (tail_i.vld) busy_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        case (cfg_index_i)
          sva_pkg::CFG_QUIET_THRESHOLD: thr_q <= cfg_data_i;
          sva_pkg::CFG_QUIET_LIMIT:     lim_q <= cfg_data_i[sva_pkg::LimW-1:0];
          default: ;
        endcase
      end
    end
  end

  assign busy_o  = busy_q;
  assign head_o  = tok_q;
  assign tgt_o   = tgt_q;
  assign limit_o = lim_q;

endmodule

`default_nettype wire

[src/synth_voice_allocator_unit.sv]
// Polyphonic voice allocator: note-on/off, all-off, reset and per-voice peak
// reports, round-robin stealing when every voice is busy.
//
// Command channel: an item is taken at a clock edge with start_i high and
// busy_o low. busy_o rises the cycle after and stays high until the result
// beat has been shown.
// Result channel: done_o is high for exactly one cycle with assigned_voice_o,
// stolen_o, released_mask_o and freed_o valid. The receiver cannot stall.
// The command token is registered in the controller and then walks the
// voice-cell chain one cell per cycle; each cell updates its own voice as
// the token passes. done_o rises as the token leaves the last cell; busy_o
// falls in the cycle after, so a new item is taken only once the last is done.
// Config: cfg_valid_i/cfg_ready_o write quiet_threshold (index 0) or
// quiet_limit (index 1); write only while busy_o is low.
// Reset: all voices free and ungated, steal pointer 0, threshold 2048,
// limit 4. No clearing pass is needed.
`default_nettype none

module synth_voice_allocator_unit #(
  parameter int VOICES = sva_pkg::VoicesDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  output logic                              busy_o,
  input  wire logic [sva_pkg::ActW-1:0]     action_i,
  input  wire logic [sva_pkg::NoteW-1:0]    note_i,
  input  wire logic [sva_pkg::VoiceW-1:0]   voice_i,
  input  wire logic [sva_pkg::PeakW-1:0]    peak_i,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [sva_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [sva_pkg::PeakW-1:0]    cfg_data_i,
  output logic                              done_o,
  output logic [sva_pkg::VoiceW-1:0]        assigned_voice_o,
  output logic                              stolen_o,
  output logic [sva_pkg::MaskW-1:0]         released_mask_o,
  output logic                              freed_o
);

  localparam int IdxW = $clog2(VOICES);

  sva_pkg::sva_token_t        tok [VOICES+1];
  logic [IdxW-1:0]            tgt [VOICES+1];
  logic [sva_pkg::LimW-1:0]   limit;

  sva_ctrl #(.VOICES(VOICES)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .action_i    (action_i),
    .note_i      (note_i),
    .voice_i     (voice_i),
    .peak_i      (peak_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .limit_o     (limit),
    .tail_i      (tok[VOICES]),
    .head_o      (tok[0]),
    .tgt_o       (tgt[0])
  );

  for (genvar i = 0; i < VOICES; i++) begin : g_cell
    sva_cell #(.VOICES(VOICES), .IDX(i)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .limit_i (limit),
      .tok_i   (tok[i]),
      .tgt_i   (tgt[i]),
      .tok_o   (tok[i+1]),
      .tgt_o   (tgt[i+1])
    );
  end

  assign done_o           = tok[VOICES].vld;
  assign assigned_voice_o = tok[VOICES].assigned;
  assign stolen_o         = (tok[VOICES].op == sva_pkg::OP_ON_STEAL);
  assign released_mask_o  = tok[VOICES].mask;
  assign freed_o          = tok[VOICES].freed;

endmodule

`default_nettype wire

[src/sva_checker.sv]
`default_nettype none

module sva_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        start_i,
  input wire logic                        busy_o,
  input wire logic                        done_o,
  input wire logic                        stolen_o,
  input wire logic [sva_pkg::MaskW-1:0]   released_mask_o,
  input wire logic                        freed_o
);

  // a result beat only belongs to an item in flight
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o)
    else $error("result beat without an item in flight");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o && !done_o)
    else $error("busy not raised after an accepted item");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy_o && !done_o)
    else $error("block not idle after its result beat");

  // a steal is a note-on: nothing released or freed in the same beat
  a_steal_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && stolen_o |-> released_mask_o == '0 && !freed_o)
    else $error("steal beat carries release or free");

endmodule

bind synth_voice_allocator_unit sva_checker u_sva_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start_i         (start_i),
  .busy_o          (busy_o),
  .done_o          (done_o),
  .stolen_o        (stolen_o),
  .released_mask_o (released_mask_o),
  .freed_o         (freed_o)
);

`default_nettype wire
